// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cpro_pkg.sv =====
// ----------------------------------------------------------------------------
// cpro_pkg
// Types, codes and arithmetic helpers of the clipped raster-op unit.
// ----------------------------------------------------------------------------
package cpro_pkg;

	localparam int unsigned DEF_SCREEN_WIDTH  = 640;
	localparam int unsigned DEF_SCREEN_HEIGHT = 480;

	localparam logic signed [15:0] CLIP_LO_RESET = 16'sd0;
	localparam logic signed [15:0] CLIP_HI_RESET = 16'sh7FFF;

	localparam logic [23:0] RGB_MASK     = 24'hFF_FFFF;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0]  ALPHA_ZERO   = 8'h00;

	typedef enum logic [2:0] {
		KIND_WRITE   = 3'd0,
		KIND_INVERT  = 3'd1,
		KIND_UBLEND  = 3'd2,
		KIND_PCBLEND = 3'd3,
		KIND_GRAD    = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		CFG_CLIP_LEFT   = 2'd0,
		CFG_CLIP_TOP    = 2'd1,
		CFG_CLIP_RIGHT  = 2'd2,
		CFG_CLIP_BOTTOM = 2'd3
	} cfg_reg_t;

	// gradient divider stage state
	typedef struct packed {
		logic [19:0] rem;
		logic [7:0]  q;
		logic [12:0] d;
		logic        zero;
		logic        sat;
	} div_t;

	// per-pixel payload through the divider stages
	typedef struct packed {
		logic        we;
		logic        mix;
		logic        grad;
		logic [18:0] addr;
		logic [31:0] fixed;
		logic [23:0] dsrc;
		logic [23:0] ssrc;
		logic [7:0]  ar;
		logic [7:0]  ag;
		logic [7:0]  ab;
	} pix_t;

	// two restoring quotient bits, hi and hi-1
	function automatic div_t div_pair(input div_t x, input logic [2:0] hi);
		div_t        r;
		logic [20:0] trial;
		logic [2:0]  lo;
		r = x;
		lo = 3'(hi - 3'd1);
		trial = 21'(x.d) << hi;
		if ({1'b0, r.rem} >= trial) begin
			r.rem = r.rem - trial[19:0];
			r.q[hi] = 1'b1;
		end
		trial = 21'(x.d) << lo;
		if ({1'b0, r.rem} >= trial) begin
			r.rem = r.rem - trial[19:0];
			r.q[lo] = 1'b1;
		end
		return r;
	endfunction

	// rounding divide by 255: (v*257 + 257) >> 16
	function automatic logic [7:0] div255(input logic [16:0] v);
		logic [24:0] acc;
		acc = {v, 8'b0} + 25'(v) + 25'd257;
		return acc[23:16];
	endfunction

endpackage

// ===== design/cpro_grad_div.sv =====
// ----------------------------------------------------------------------------
// cpro_grad_div
// Gradient weight row*255/(height-1), saturated at 255, two quotient bits
// per stage. Result lines up with pipeline stage 5.
// ----------------------------------------------------------------------------
module cpro_grad_div
	import cpro_pkg::*;
(
	input  logic        clk,
	input  logic [11:0] row_in_band,
	input  logic [12:0] band_height,
	output logic [7:0]  weight
);

	div_t        div_c;
	div_t        div_s1;
	div_t        div_s2;
	div_t        div_s3;
	div_t        div_s4;
	div_t        div_s5;
	logic [19:0] numer;

	always_comb begin
		numer = {row_in_band, 8'b0} - 20'(row_in_band);
		div_c.rem = numer;
		div_c.q = '0;
		div_c.d = band_height - 13'd1;
		div_c.zero = (band_height <= 13'd1);
		div_c.sat = ({1'b0, numer} >= {div_c.d, 8'b0});
	end

	always_ff @(posedge clk) begin
		div_s1 <= div_c;
		div_s2 <= div_pair(div_s1, 3'd7);
		div_s3 <= div_pair(div_s2, 3'd5);
		div_s4 <= div_pair(div_s3, 3'd3);
		div_s5 <= div_pair(div_s4, 3'd1);
	end

	always_comb begin
		priority if (div_s5.zero) begin
			weight = ALPHA_ZERO;
		end else if (div_s5.sat) begin
			weight = ALPHA_OPAQUE;
		end else begin
			weight = div_s5.q;
		end
	end

endmodule

// ===== design/cpro_mix_chan.sv =====
// ----------------------------------------------------------------------------
// cpro_mix_chan
// One color channel blend: div255(dst*(255-a) + src*a). Products are
// registered at stage 6.
// ----------------------------------------------------------------------------
module cpro_mix_chan
	import cpro_pkg::*;
(
	input  logic       clk,
	input  logic [7:0] dst,
	input  logic [7:0] src,
	input  logic [7:0] alpha,
	output logic [7:0] mixed
);

	logic [15:0] dst_term_s6;
	logic [15:0] src_term_s6;

	always_ff @(posedge clk) begin
		dst_term_s6 <= 16'(dst) * 16'(ALPHA_OPAQUE - alpha);
		src_term_s6 <= 16'(src) * 16'(alpha);
	end

	assign mixed = div255(17'(dst_term_s6) + 17'(src_term_s6));

endmodule

// ===== design/clipped_pixel_raster_op_unit.sv =====
// ----------------------------------------------------------------------------
// clipped_pixel_raster_op_unit
// Per-pixel raster op for a 32-bit ABGR framebuffer: clip test, linear
// address, and write / invert / blend / gradient pixel value.
//
// Channel   Handshake                  Payload
// --------  -------------------------  ------------------------------------
// command   start, busy                kind, pixel_x/y, colors, alphas, band
// result    result_strobe              write_enable, pixel_address, new_pixel
// config    cfg_valid, cfg_ready       cfg_index, cfg_data
//
// One pixel per clock; busy stays low. The result strobe is registered
// through the clip/address stage, four divider stages of two quotient
// bits each, the blend multiply stage and the output register.
// Reset clears the valid bits and sets the clip window to the whole screen.
// Results cannot be stalled; config writes are always taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clipped_pixel_raster_op_unit
	import cpro_pkg::*;
#(
	parameter int unsigned SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int unsigned SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         kind,
	input  logic signed [15:0] pixel_x,
	input  logic signed [15:0] pixel_y,
	input  logic [31:0]        dest_pixel,
	input  logic [31:0]        color_a,
	input  logic [31:0]        color_b,
	input  logic [7:0]         alpha_red,
	input  logic [7:0]         alpha_green,
	input  logic [7:0]         alpha_blue,
	input  logic [11:0]        row_in_band,
	input  logic [12:0]        band_height,
	output logic               result_strobe,
	output logic               write_enable,
	output logic [18:0]        pixel_address,
	output logic [31:0]        new_pixel,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam int unsigned LATENCY = 7;
	localparam int unsigned ADDR_SPAN = 1 << 19;
	localparam int unsigned ADDR_LIMIT = (SCREEN_WIDTH * SCREEN_HEIGHT < ADDR_SPAN) ?
		SCREEN_WIDTH * SCREEN_HEIGHT : ADDR_SPAN;
	localparam logic signed [15:0] SW = 16'(SCREEN_WIDTH);
	localparam logic signed [15:0] SH = 16'(SCREEN_HEIGHT);
	localparam logic [18:0] W19 = 19'(SCREEN_WIDTH);

	typedef struct packed {
		logic        we;
		logic        mix;
		logic [18:0] addr;
		logic [31:0] fixed;
	} out_t;

	logic signed [15:0] clip_left_q;
	logic signed [15:0] clip_top_q;
	logic signed [15:0] clip_right_q;
	logic signed [15:0] clip_bottom_q;

	logic signed [15:0] x_lo;
	logic signed [15:0] x_hi;
	logic signed [15:0] y_lo;
	logic signed [15:0] y_hi;
	logic               in_clip;
	logic               accept;
	pix_t               pl_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	pix_t pl_s1, pl_s2, pl_s3, pl_s4, pl_s5;
	out_t pl_s6;
	logic        we_s7;
	logic [18:0] addr_s7;
	logic [31:0] px_s7;

	logic [7:0] grad_t;
	logic [7:0] a_r, a_g, a_b;
	logic [7:0] mix_r, mix_g, mix_b;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q <= CLIP_LO_RESET;
			clip_top_q <= CLIP_LO_RESET;
			clip_right_q <= CLIP_HI_RESET;
			clip_bottom_q <= CLIP_HI_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CLIP_LEFT: clip_left_q <= cfg_data;
				CFG_CLIP_TOP: clip_top_q <= cfg_data;
				CFG_CLIP_RIGHT: clip_right_q <= cfg_data;
				CFG_CLIP_BOTTOM: clip_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: clip window, address, op decode
	always_comb begin
		x_lo = (clip_left_q > 16'sd0) ? clip_left_q : 16'sd0;
		y_lo = (clip_top_q > 16'sd0) ? clip_top_q : 16'sd0;
		x_hi = (clip_right_q < SW) ? clip_right_q : SW;
		y_hi = (clip_bottom_q < SH) ? clip_bottom_q : SH;
		in_clip = (pixel_x >= x_lo) && (pixel_x < x_hi) &&
			(pixel_y >= y_lo) && (pixel_y < y_hi);

		pl_c.addr = 19'(pixel_y) * W19 + 19'(pixel_x);
		pl_c.grad = (kind == KIND_GRAD);
		pl_c.dsrc = pl_c.grad ? color_a[23:0] : dest_pixel[23:0];
		pl_c.ssrc = pl_c.grad ? color_b[23:0] : color_a[23:0];
		pl_c.ar = alpha_red;
		pl_c.ag = (kind == KIND_UBLEND) ? alpha_red : alpha_green;
		pl_c.ab = (kind == KIND_UBLEND) ? alpha_red : alpha_blue;
		pl_c.we = 1'b0;
		pl_c.mix = 1'b0;
		pl_c.fixed = dest_pixel;
		if (in_clip) begin
			unique case (kind)
				KIND_WRITE: begin
					pl_c.we = 1'b1;
					pl_c.fixed = color_a;
				end
				KIND_INVERT: begin
					pl_c.we = 1'b1;
					pl_c.fixed = {dest_pixel[31:24], dest_pixel[23:0] ^ RGB_MASK};
				end
				KIND_UBLEND: begin
					pl_c.we = (alpha_red != ALPHA_ZERO);
					pl_c.mix = (alpha_red != ALPHA_ZERO) && (alpha_red != ALPHA_OPAQUE);
					if (alpha_red == ALPHA_OPAQUE) begin
						pl_c.fixed = color_a;
					end
				end
				KIND_PCBLEND, KIND_GRAD: begin
					pl_c.we = 1'b1;
					pl_c.mix = 1'b1;
				end
				default: ;
			endcase
		end
	end

	cpro_grad_div u_div (
		.clk         (clk),
		.row_in_band (row_in_band),
		.band_height (band_height),
		.weight      (grad_t)
	);

	assign a_r = pl_s5.grad ? grad_t : pl_s5.ar;
	assign a_g = pl_s5.grad ? grad_t : pl_s5.ag;
	assign a_b = pl_s5.grad ? grad_t : pl_s5.ab;

	cpro_mix_chan u_mix_r (
		.clk   (clk),
		.dst   (pl_s5.dsrc[7:0]),
		.src   (pl_s5.ssrc[7:0]),
		.alpha (a_r),
		.mixed (mix_r)
	);

	cpro_mix_chan u_mix_g (
		.clk   (clk),
		.dst   (pl_s5.dsrc[15:8]),
		.src   (pl_s5.ssrc[15:8]),
		.alpha (a_g),
		.mixed (mix_g)
	);

	cpro_mix_chan u_mix_b (
		.clk   (clk),
		.dst   (pl_s5.dsrc[23:16]),
		.src   (pl_s5.ssrc[23:16]),
		.alpha (a_b),
		.mixed (mix_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		pl_s1 <= pl_c;
		pl_s2 <= pl_s1;
		pl_s3 <= pl_s2;
		pl_s4 <= pl_s3;
		pl_s5 <= pl_s4;
		pl_s6.we <= pl_s5.we;
		pl_s6.mix <= pl_s5.mix;
		pl_s6.addr <= pl_s5.addr;
		pl_s6.fixed <= pl_s5.fixed;
		we_s7 <= pl_s6.we;
		addr_s7 <= pl_s6.we ? pl_s6.addr : '0;
		px_s7 <= pl_s6.mix ? {ALPHA_OPAQUE, mix_b, mix_g, mix_r} : pl_s6.fixed;
	end

	assign result_strobe = v_s7;
	assign write_enable = we_s7;
	assign pixel_address = addr_s7;
	assign new_pixel = px_s7;

	`ASSERT_IMPLIES(a_strobe_latency, clk, arst_n, result_strobe,
		$past(start && !busy, LATENCY), "result strobe without an earlier transfer")
	`ASSERT_IMPLIES(a_skip_addr, clk, arst_n, result_strobe && !write_enable,
		pixel_address == '0, "skipped pixel carries an address")
	`ASSERT_IMPLIES(a_addr_range, clk, arst_n, result_strobe && write_enable,
		32'(pixel_address) < ADDR_LIMIT, "written address beyond the screen")
	`ASSERT_NEXT(a_blend_opaque, clk, arst_n, v_s6 && pl_s6.mix,
		write_enable && (new_pixel[31:24] == ALPHA_OPAQUE), "blend result not opaque")

endmodule
